@@ src/hbfs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HVAC bus frame status decoder package
// Shared types, register indexes, frame positions and code constants.
// ---------------------------------------------------------------------------
package hbfs_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DEST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDR  = 3'd4;

  // Register reset values.
  localparam logic [7:0] START_MARK_RST = 8'h32;
  localparam logic [7:0] END_MARK_RST   = 8'h34;
  localparam logic [7:0] PAUSE_DEST_RST = 8'hAD;

  // Byte positions inside a frame, counted after the start mark.
  localparam logic [3:0] POS_SRC    = 4'd0;
  localparam logic [3:0] POS_DST    = 4'd1;
  localparam logic [3:0] POS_CMD    = 4'd2;
  localparam logic [3:0] POS_TEMP   = 4'd3;
  localparam logic [3:0] POS_FAN    = 4'd6;
  localparam logic [3:0] POS_POWER  = 4'd7;
  localparam logic [3:0] POS_MODE   = 4'd10;
  localparam logic [3:0] POS_CHKSUM = 4'd11;
  localparam logic [3:0] POS_END    = 4'd12;

  // Commands.
  localparam logic [7:0] CMD_STATUS = 8'h52;
  localparam logic [7:0] CMD_MODE   = 8'h53;

  // Status decoding constants.
  localparam logic [5:0] TEMP_OFFSET  = 6'd9;
  localparam logic [7:0] MODE_MAX     = 8'd4;
  localparam logic [2:0] MODE_UNKNOWN = 3'd5;

  localparam logic [1:0] POWER_UNKNOWN = 2'd0;
  localparam logic [1:0] POWER_OFF     = 2'd1;
  localparam logic [1:0] POWER_ON      = 2'd2;

  localparam logic [2:0] FAN_UNKNOWN = 3'd0;
  localparam logic [2:0] FAN_AUTO    = 3'd1;
  localparam logic [2:0] FAN_MIN     = 3'd2;
  localparam logic [2:0] FAN_MID     = 3'd3;
  localparam logic [2:0] FAN_MAX     = 3'd4;

  localparam logic [3:0] FAN_NIB_MIN = 4'hA;
  localparam logic [3:0] FAN_NIB_MID = 4'hC;
  localparam logic [3:0] FAN_NIB_MAX = 4'hD;

  typedef enum logic [1:0] {
    FS_OK      = 2'd0,
    FS_BAD_END = 2'd1,
    FS_BAD_SUM = 2'd2
  } frame_status_t;

  // Fields of a completed frame handed from the collector to the tracker.
  typedef struct packed {
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] cmd;
    logic [4:0] temp_bits;
    logic [3:0] fan_nib;
    logic       power_bit;
    logic [7:0] mode_byte;
    logic       sum_ok;
    logic       end_ok;
  } frame_t;

  // One decoded result.
  typedef struct packed {
    frame_status_t frame_status;
    logic [7:0]    source_address;
    logic [7:0]    dest_address;
    logic [7:0]    command;
    logic          send_window;
    logic [5:0]    set_temperature;
    logic [1:0]    power_state;
    logic [2:0]    fan_speed;
    logic [2:0]    op_mode;
    logic          status_changed;
  } result_t;

  // Map the low nibble of the fan byte to a fan speed code.
  function automatic logic [2:0] fan_code(input logic [3:0] nib);
    logic [2:0] code;
    unique case (nib)
      FAN_NIB_MIN: code = FAN_MIN;
      FAN_NIB_MID: code = FAN_MID;
      FAN_NIB_MAX: code = FAN_MAX;
      default:     code = FAN_AUTO;
    endcase
    return code;
  endfunction

endpackage

@@ src/hbfs_in_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one bus byte per request.
// ---------------------------------------------------------------------------
interface hbfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ src/hbfs_out_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one decoded frame result per request.
// ---------------------------------------------------------------------------
interface hbfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [7:0] source_address;
  logic [7:0] dest_address;
  logic [7:0] command;
  logic       send_window;
  logic [5:0] set_temperature;
  logic [1:0] power_state;
  logic [2:0] fan_speed;
  logic [2:0] op_mode;
  logic       status_changed;

  modport source (
    output valid, output frame_status, output source_address, output dest_address,
    output command, output send_window, output set_temperature, output power_state,
    output fan_speed, output op_mode, output status_changed, input ready
  );
  modport sink (
    input valid, input frame_status, input source_address, input dest_address,
    input command, input send_window, input set_temperature, input power_state,
    input fan_speed, input op_mode, input status_changed, output ready
  );
endinterface

@@ src/hbfs_collector.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame collector
// Hunts for the start mark, counts frame bytes, keeps the fields that the
// decoder needs and folds the checksum as the bytes go by.
// ---------------------------------------------------------------------------
module hbfs_collector (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic [7:0]    byte_in,
  input  logic [7:0]    start_mark,
  input  logic [7:0]    end_mark,
  output logic          last,
  output hbfs_pkg::frame_t frame
);

  logic       in_frame_r, in_frame_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] xor_r;
  logic [7:0] src_r, dst_r, cmd_r, mode_r;
  logic [4:0] temp_r;
  logic [3:0] fan_r;
  logic       power_r;
  logic       sum_ok_r;

  // The byte at the head of the pipe closes the frame.
  assign last = in_frame_r && (cnt_r == hbfs_pkg::POS_END);

  // Frame tracking control.
  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    if (byte_en) begin
      if (!in_frame_r) begin
        if (byte_in == start_mark) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
        end
      end else if (last) begin
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Field capture and running checksum.
  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (!in_frame_r) begin
        xor_r <= '0;
      end else begin
        if (cnt_r < hbfs_pkg::POS_CHKSUM) begin
          xor_r <= xor_r ^ byte_in;
        end
        unique case (cnt_r)
          hbfs_pkg::POS_SRC:    src_r    <= byte_in;
          hbfs_pkg::POS_DST:    dst_r    <= byte_in;
          hbfs_pkg::POS_CMD:    cmd_r    <= byte_in;
          hbfs_pkg::POS_TEMP:   temp_r   <= byte_in[4:0];
          hbfs_pkg::POS_FAN:    fan_r    <= byte_in[3:0];
          hbfs_pkg::POS_POWER:  power_r  <= byte_in[7];
          hbfs_pkg::POS_MODE:   mode_r   <= byte_in;
          hbfs_pkg::POS_CHKSUM: sum_ok_r <= (byte_in == xor_r);
          default: ;
        endcase
      end
    end
  end

  // Completed frame fields; the end byte is the one now being taken.
  always_comb begin
    frame.src       = src_r;
    frame.dst       = dst_r;
    frame.cmd       = cmd_r;
    frame.temp_bits = temp_r;
    frame.fan_nib   = fan_r;
    frame.power_bit = power_r;
    frame.mode_byte = mode_r;
    frame.sum_ok    = sum_ok_r;
    frame.end_ok    = (byte_in == end_mark);
  end

endmodule

@@ src/hbfs_tracker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Status tracker
// Checks a completed frame, updates the tracked unit status and holds the
// result in the output register until it is taken.
// ---------------------------------------------------------------------------
module hbfs_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                frame_en,
  input  hbfs_pkg::frame_t    frame,
  input  logic [7:0]          pause_dest,
  input  logic [7:0]          machine_address,
  input  logic [7:0]          remote_address,
  input  logic                res_ready,
  output logic                res_valid,
  output hbfs_pkg::result_t   res
);

  hbfs_pkg::frame_status_t status;
  logic       frame_ok, to_remote;
  logic [5:0] temp_r, temp_nxt;
  logic [1:0] power_r, power_nxt;
  logic [2:0] fan_r, fan_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [5:0] temp_new;
  logic [1:0] power_new;
  logic [2:0] fan_new;
  logic       changed;
  logic       res_valid_r;
  hbfs_pkg::result_t res_r, res_nxt;

  // End mark is checked before the checksum.
  always_comb begin
    priority if (!frame.end_ok) begin
      status = hbfs_pkg::FS_BAD_END;
    end else if (!frame.sum_ok) begin
      status = hbfs_pkg::FS_BAD_SUM;
    end else begin
      status = hbfs_pkg::FS_OK;
    end
  end

  assign frame_ok  = (status == hbfs_pkg::FS_OK);
  assign to_remote = frame_ok && (frame.src == machine_address) &&
                     (frame.dst == remote_address);

  assign temp_new  = {1'b0, frame.temp_bits} + hbfs_pkg::TEMP_OFFSET;
  assign power_new = frame.power_bit ? hbfs_pkg::POWER_ON : hbfs_pkg::POWER_OFF;
  assign fan_new   = hbfs_pkg::fan_code(frame.fan_nib);

  // Next tracked status from a valid machine-to-remote frame.
  always_comb begin
    temp_nxt  = temp_r;
    power_nxt = power_r;
    fan_nxt   = fan_r;
    mode_nxt  = mode_r;
    if (to_remote && (frame.cmd == hbfs_pkg::CMD_MODE) &&
        (frame.mode_byte <= hbfs_pkg::MODE_MAX)) begin
      mode_nxt = frame.mode_byte[2:0];
    end
    if (to_remote && (frame.cmd == hbfs_pkg::CMD_STATUS)) begin
      temp_nxt  = temp_new;
      power_nxt = power_new;
      fan_nxt   = fan_new;
    end
    changed = (temp_nxt != temp_r) || (power_nxt != power_r) ||
              (fan_nxt != fan_r) || (mode_nxt != mode_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r  <= '0;
      power_r <= hbfs_pkg::POWER_UNKNOWN;
      fan_r   <= hbfs_pkg::FAN_UNKNOWN;
      mode_r  <= hbfs_pkg::MODE_UNKNOWN;
    end else if (frame_en) begin
      temp_r  <= temp_nxt;
      power_r <= power_nxt;
      fan_r   <= fan_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // Result word for the output register.
  always_comb begin
    res_nxt.frame_status    = status;
    res_nxt.source_address  = frame.src;
    res_nxt.dest_address    = frame.dst;
    res_nxt.command         = frame.cmd;
    res_nxt.send_window     = frame_ok && (frame.dst == pause_dest);
    res_nxt.set_temperature = temp_nxt;
    res_nxt.power_state     = power_nxt;
    res_nxt.fan_speed       = fan_nxt;
    res_nxt.op_mode         = mode_nxt;
    res_nxt.status_changed  = changed;
  end

  // Output register: a new result replaces one that is being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (frame_en) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_en) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ src/hvac_bus_frame_status_decoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HVAC bus frame status decoder
// Collects 13-byte bus frames after a start mark, checks them and reports
// the frame header together with the tracked indoor unit status.
// ---------------------------------------------------------------------------
// The decoder takes one received byte per clock cycle unless the output
// stalls: a byte enters the input register, and from there the collector
// and the status tracker handle it in a single pass; a frame's result is
// registered as its end byte leaves the input register. The output
// register stalls the byte pipe only when a finished frame meets a result
// that has not yet been taken. The user must write the configuration
// registers through the cfg port only while no frame is in flight; the
// block does not enforce it. Indexes above the last register are ignored.
module hvac_bus_frame_status_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  hbfs_in_if.sink                              in_ch,
  hbfs_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [hbfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                           cfg_wdata
);

  logic [7:0] start_mark_r, end_mark_r, pause_dest_r, machine_addr_r, remote_addr_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       last, advance, res_valid;
  hbfs_pkg::frame_t  frame;
  hbfs_pkg::result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r   <= hbfs_pkg::START_MARK_RST;
      end_mark_r     <= hbfs_pkg::END_MARK_RST;
      pause_dest_r   <= hbfs_pkg::PAUSE_DEST_RST;
      machine_addr_r <= '0;
      remote_addr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbfs_pkg::CFG_START_MARK:   start_mark_r   <= cfg_wdata;
        hbfs_pkg::CFG_END_MARK:     end_mark_r     <= cfg_wdata;
        hbfs_pkg::CFG_PAUSE_DEST:   pause_dest_r   <= cfg_wdata;
        hbfs_pkg::CFG_MACHINE_ADDR: machine_addr_r <= cfg_wdata;
        hbfs_pkg::CFG_REMOTE_ADDR:  remote_addr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The held byte moves on unless it closes a frame whose result has no room.
  assign advance     = s1_valid_r && (!last || !res_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  hbfs_collector u_collector (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (advance),
    .byte_in    (s1_byte_r),
    .start_mark (start_mark_r),
    .end_mark   (end_mark_r),
    .last       (last),
    .frame      (frame)
  );

  hbfs_tracker u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame_en        (advance && last),
    .frame           (frame),
    .pause_dest      (pause_dest_r),
    .machine_address (machine_addr_r),
    .remote_address  (remote_addr_r),
    .res_ready       (out_ch.ready),
    .res_valid       (res_valid),
    .res             (res)
  );

  // Result channel.
  assign out_ch.valid           = res_valid;
  assign out_ch.frame_status    = res.frame_status;
  assign out_ch.source_address  = res.source_address;
  assign out_ch.dest_address    = res.dest_address;
  assign out_ch.command         = res.command;
  assign out_ch.send_window     = res.send_window;
  assign out_ch.set_temperature = res.set_temperature;
  assign out_ch.power_state     = res.power_state;
  assign out_ch.fan_speed       = res.fan_speed;
  assign out_ch.op_mode         = res.op_mode;
  assign out_ch.status_changed  = res.status_changed;

endmodule

@@ src/hbfs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame decoder port checker
// Watches the result channel of the decoder and flags illegal results.
// ---------------------------------------------------------------------------
module hbfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status,
  input logic [7:0] source_address,
  input logic       send_window,
  input logic       status_changed
);

  // A stalled request stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled request keeps its frame status and source address.
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(frame_status) && $stable(source_address))
    else $error("result payload changed while stalled");

  // Only three status codes exist.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_status == hbfs_pkg::FS_OK) ||
                  (frame_status == hbfs_pkg::FS_BAD_END) ||
                  (frame_status == hbfs_pkg::FS_BAD_SUM))
    else $error("illegal frame status code");

  // A transmit window opens only on a valid frame.
  a_window_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && send_window |-> frame_status == hbfs_pkg::FS_OK)
    else $error("send window on a rejected frame");

  // Tracked status only changes on a valid frame.
  a_change_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_changed |-> frame_status == hbfs_pkg::FS_OK)
    else $error("status change on a rejected frame");

endmodule

bind hvac_bus_frame_status_decoder hbfs_checker u_hbfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .frame_status   (out_ch.frame_status),
  .source_address (out_ch.source_address),
  .send_window    (out_ch.send_window),
  .status_changed (out_ch.status_changed)
);

@@ tb/hvac_bus_frame_status_decoder_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HVAC bus frame status decoder testbench
// Feeds received bus bytes through the valid/ready input channel and checks
// every frame result against a cycle-free predictor of the decoder. A short
// table of directed frames comes first, then random frames, broken frames
// and line noise under several register settings. Both channels idle at
// random, and the result side holds off for long stretches at times so that
// the decoder has to stall its input.
// ---------------------------------------------------------------------------
module hvac_bus_frame_status_decoder_test;
  import hbfs_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned FRAME_BYTES   = 13;
  localparam int unsigned SUM_BYTES     = 11;
  localparam int unsigned MAX_GAP       = 10;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 10;
  localparam int unsigned PHASE_BYTES   = 160;
  localparam int unsigned NUM_ROWS      = 17;
  localparam int unsigned NUM_REGS      = 5;
  localparam int unsigned TIMEOUT_NS    = 400000 * CLK_PERIOD;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_bytes_t;
  typedef enum logic { ROW_NOISE, ROW_FRAME } row_kind_t;

  // One row of the directed plan: a lone byte or a whole frame.
  typedef struct packed {
    row_kind_t    kind;
    frame_bytes_t bytes;
    logic         fix_sum;
    logic         typed;
    result_t      want;
  } row_t;

  localparam result_t NO_CHECK = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  hbfs_in_if  in_ch ();
  hbfs_out_if out_ch ();

  hvac_bus_frame_status_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the registers and the decoder state.
  logic [7:0] start_mark_r, end_mark_r, pause_dest_r, machine_addr_r, remote_addr_r;
  frame_bytes_t collect_buf;
  int unsigned  collect_cnt;
  logic         collecting;
  logic [5:0]   temp_q;
  logic [1:0]   power_q;
  logic [2:0]   fan_q;
  logic [2:0]   mode_q;

  result_t     frame_results_q [$];
  result_t     typed_result;
  logic        use_typed;
  logic        no_gap;
  logic        long_hold_req;
  int unsigned frame_bytes_sent;
  int unsigned fail_count;
  row_t        plan [NUM_ROWS];

  // Register write as seen by the decoder; unused indexes are dropped.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      CFG_START_MARK:   start_mark_r   = val;
      CFG_END_MARK:     end_mark_r     = val;
      CFG_PAUSE_DEST:   pause_dest_r   = val;
      CFG_MACHINE_ADDR: machine_addr_r = val;
      CFG_REMOTE_ADDR:  remote_addr_r  = val;
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted byte and queue the frame result
  // when the byte completes a frame.
  task automatic predict_byte(input logic [7:0] b);
    logic [7:0] sum;
    logic [5:0] t;
    logic [1:0] p;
    logic [2:0] f;
    result_t    r;
    if (!collecting) begin
      if (b == start_mark_r) begin
        collecting  = 1'b1;
        collect_cnt = 0;
      end
      return;
    end
    collect_buf[collect_cnt] = b;
    collect_cnt++;
    if (collect_cnt < FRAME_BYTES) return;
    collecting  = 1'b0;
    collect_cnt = 0;

    sum = 8'h00;
    for (int k = 0; k < SUM_BYTES; k++) sum ^= collect_buf[k];

    r = '0;
    if (collect_buf[POS_END] != end_mark_r) r.frame_status = FS_BAD_END;
    else if (collect_buf[POS_CHKSUM] != sum) r.frame_status = FS_BAD_SUM;
    else r.frame_status = FS_OK;

    // Only a clean frame from the indoor unit to the remote moves the status.
    if (r.frame_status == FS_OK) begin
      r.send_window = (collect_buf[POS_DST] == pause_dest_r);
      if (collect_buf[POS_SRC] == machine_addr_r && collect_buf[POS_DST] == remote_addr_r) begin
        if (collect_buf[POS_CMD] == CMD_MODE && collect_buf[POS_MODE] <= MODE_MAX &&
            collect_buf[POS_MODE][2:0] != mode_q) begin
          mode_q = collect_buf[POS_MODE][2:0];
          r.status_changed = 1'b1;
        end
        if (collect_buf[POS_CMD] == CMD_STATUS) begin
          t = {1'b0, collect_buf[POS_TEMP][4:0]} + TEMP_OFFSET;
          p = collect_buf[POS_POWER][7] ? POWER_ON : POWER_OFF;
          case (collect_buf[POS_FAN][3:0])
            FAN_NIB_MIN: f = FAN_MIN;
            FAN_NIB_MID: f = FAN_MID;
            FAN_NIB_MAX: f = FAN_MAX;
            default:     f = FAN_AUTO;
          endcase
          if (t != temp_q)  begin temp_q  = t; r.status_changed = 1'b1; end
          if (p != power_q) begin power_q = p; r.status_changed = 1'b1; end
          if (f != fan_q)   begin fan_q   = f; r.status_changed = 1'b1; end
        end
      end
    end

    r.source_address  = collect_buf[POS_SRC];
    r.dest_address    = collect_buf[POS_DST];
    r.command         = collect_buf[POS_CMD];
    r.set_temperature = temp_q;
    r.power_state     = power_q;
    r.fan_speed       = fan_q;
    r.op_mode         = mode_q;
    frame_results_q.push_back(use_typed ? typed_result : r);
  endtask

  // Offer one byte after a random gap and wait until the decoder takes it.
  // Called at a rising edge; valid is lowered only when a gap follows.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (collecting || b == start_mark_r) frame_bytes_sent++;
    predict_byte(b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Start mark followed by the 13 frame bytes.
  task automatic send_frame(input frame_bytes_t fb, input logic fix_sum);
    logic [7:0] sum;
    if (fix_sum) begin
      sum = 8'h00;
      for (int k = 0; k < SUM_BYTES; k++) sum ^= fb[k];
      fb[POS_CHKSUM] = sum;
    end
    send_byte(start_mark_r);
    for (int k = 0; k < FRAME_BYTES; k++) send_byte(fb[k]);
  endtask

  // Wait until every expected result is in and the pipe has run dry.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back, plus one write to an unused index.
  task automatic program_regs(input logic [7:0] s, input logic [7:0] e, input logic [7:0] p,
                              input logic [7:0] m, input logic [7:0] r);
    logic [7:0] vals [NUM_REGS + 1];
    logic [CFG_IDX_W-1:0] idx;
    vals = '{s, e, p, m, r, 8'($urandom_range(0, 255))};
    for (int k = 0; k <= NUM_REGS; k++) begin
      idx = (k < NUM_REGS) ? CFG_IDX_W'(k)
                           : CFG_IDX_W'($urandom_range(CFG_REMOTE_ADDR + 1, (1 << CFG_IDX_W) - 1));
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[k];
      apply_reg(idx, vals[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_addr(input logic [7:0] likely);
    case ($urandom_range(0, 5))
      0, 1, 2: return likely;
      3:       return machine_addr_r;
      4:       return pause_dest_r;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic row_t frame_row(input logic [7:0] src, input logic [7:0] dst,
                                     input logic [7:0] cmd, input logic [7:0] fill,
                                     input logic [7:0] temp, input logic [7:0] fan,
                                     input logic [7:0] pwr, input logic [7:0] mode,
                                     input logic [7:0] sum, input logic [7:0] endb,
                                     input logic fix, input logic typed, input result_t want);
    row_t row;
    row.kind = ROW_FRAME;
    for (int k = 0; k < FRAME_BYTES; k++) row.bytes[k] = fill;
    row.bytes[POS_SRC]    = src;
    row.bytes[POS_DST]    = dst;
    row.bytes[POS_CMD]    = cmd;
    row.bytes[POS_TEMP]   = temp;
    row.bytes[POS_FAN]    = fan;
    row.bytes[POS_POWER]  = pwr;
    row.bytes[POS_MODE]   = mode;
    row.bytes[POS_CHKSUM] = sum;
    row.bytes[POS_END]    = endb;
    row.fix_sum = fix;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  function automatic row_t noise_row(input logic [7:0] b);
    row_t row;
    row = '0;
    row.kind     = ROW_NOISE;
    row.bytes[0] = b;
    return row;
  endfunction

  // Random traffic: mostly well-formed frames, some noise and cut-off frames.
  task automatic random_phase(input logic hold);
    int unsigned  start_count;
    int unsigned  pick;
    frame_bytes_t fb;
    logic         fix;
    logic [7:0]   b;
    if (hold) long_hold_req = 1'b1;
    start_count = frame_bytes_sent;
    while (frame_bytes_sent - start_count < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 && !collecting) begin
        b = 8'($urandom_range(0, 255));
        send_byte((b == start_mark_r) ? ~b : b);
      end else if (pick < 16) begin
        send_byte(start_mark_r);
        repeat ($urandom_range(1, FRAME_BYTES - 1)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        for (int k = 0; k < FRAME_BYTES; k++) fb[k] = 8'($urandom_range(0, 255));
        fb[POS_SRC] = pick_addr(machine_addr_r);
        fb[POS_DST] = pick_addr(remote_addr_r);
        case ($urandom_range(0, 4))
          0, 1:    fb[POS_CMD] = CMD_STATUS;
          2, 3:    fb[POS_CMD] = CMD_MODE;
          default: ;
        endcase
        if ($urandom_range(0, 1)) fb[POS_MODE] = 8'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 88) fb[POS_END] = end_mark_r;
        fix    = ($urandom_range(0, 99) < 85);
        no_gap = ($urandom_range(0, 99) < 30);
        send_frame(fb, fix);
        no_gap = 1'b0;
      end
    end
    // Close any open frame so that registers change only between frames.
    while (collecting) send_byte(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: random stalls, quiet runs, and long hold-offs on request.
  initial begin : result_sink
    int unsigned stall;
    int unsigned quiet_run;
    result_t     got;
    result_t     want;
    out_ch.ready <= 1'b0;
    quiet_run = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (quiet_run > 0) begin
        quiet_run--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 4) == 0) quiet_run = $urandom_range(4, 12);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);

      got.frame_status    = frame_status_t'(out_ch.frame_status);
      got.source_address  = out_ch.source_address;
      got.dest_address    = out_ch.dest_address;
      got.command         = out_ch.command;
      got.send_window     = out_ch.send_window;
      got.set_temperature = out_ch.set_temperature;
      got.power_state     = out_ch.power_state;
      got.fan_speed       = out_ch.fan_speed;
      got.op_mode         = out_ch.op_mode;
      got.status_changed  = out_ch.status_changed;

      if (frame_results_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = frame_results_q.pop_front();
        check_field("frame_status", want.frame_status, got.frame_status);
        check_field("source_address", want.source_address, got.source_address);
        check_field("dest_address", want.dest_address, got.dest_address);
        check_field("command", want.command, got.command);
        check_field("send_window", want.send_window, got.send_window);
        check_field("set_temperature", want.set_temperature, got.set_temperature);
        check_field("power_state", want.power_state, got.power_state);
        check_field("fan_speed", want.fan_speed, got.fan_speed);
        check_field("op_mode", want.op_mode, got.op_mode);
        check_field("status_changed", want.status_changed, got.status_changed);
      end
    end
  end

  // Main sequence: reset, directed plan, then random phases.
  initial begin : stimulus
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;

    start_mark_r   = START_MARK_RST;
    end_mark_r     = END_MARK_RST;
    pause_dest_r   = PAUSE_DEST_RST;
    machine_addr_r = 8'h00;
    remote_addr_r  = 8'h00;
    collect_buf    = '0;
    collect_cnt    = 0;
    collecting     = 1'b0;
    temp_q         = 6'd0;
    power_q        = POWER_UNKNOWN;
    fan_q          = FAN_UNKNOWN;
    mode_q         = MODE_UNKNOWN;
    use_typed      = 1'b0;
    typed_result   = NO_CHECK;
    no_gap         = 1'b0;
    long_hold_req  = 1'b0;
    frame_bytes_sent = 0;
    fail_count     = 0;

    // Directed plan under reset register values (machine and remote at 0).
    plan[0]  = noise_row(8'h00);
    plan[1]  = noise_row(8'hFF);
    plan[2]  = noise_row(8'h33);
    // Wrong end byte on an otherwise clean frame.
    plan[3]  = frame_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                         8'h35, 1'b0, 1'b1,
                         '{FS_BAD_END, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0,
                           POWER_UNKNOWN, FAN_UNKNOWN, MODE_UNKNOWN, 1'b0});
    // Wrong end and wrong checksum: the end check wins.
    plan[4]  = frame_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                         8'hFF, 1'b0, 1'b1,
                         '{FS_BAD_END, 8'hFF, 8'hFF, 8'hFF, 1'b0, 6'd0,
                           POWER_UNKNOWN, FAN_UNKNOWN, MODE_UNKNOWN, 1'b0});
    // Status frame with a wrong checksum leaves the status alone.
    plan[5]  = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'hFF, 8'h0D, 8'h80, 8'h00, 8'h00,
                         END_MARK_RST, 1'b0, 1'b1,
                         '{FS_BAD_SUM, 8'h00, 8'h00, CMD_STATUS, 1'b0, 6'd0,
                           POWER_UNKNOWN, FAN_UNKNOWN, MODE_UNKNOWN, 1'b0});
    // Highest temperature, power on, top fan speed.
    plan[6]  = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'hFF, 8'h0D, 8'h80, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b1,
                         '{FS_OK, 8'h00, 8'h00, CMD_STATUS, 1'b0, 6'd40,
                           POWER_ON, FAN_MAX, MODE_UNKNOWN, 1'b1});
    // The same frame again changes nothing.
    plan[7]  = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'hFF, 8'h0D, 8'h80, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b1,
                         '{FS_OK, 8'h00, 8'h00, CMD_STATUS, 1'b0, 6'd40,
                           POWER_ON, FAN_MAX, MODE_UNKNOWN, 1'b0});
    // Lowest temperature, power off, lowest fan speed.
    plan[8]  = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'hE0, 8'hFA, 8'h7F, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b1,
                         '{FS_OK, 8'h00, 8'h00, CMD_STATUS, 1'b0, 6'd9,
                           POWER_OFF, FAN_MIN, MODE_UNKNOWN, 1'b1});
    plan[9]  = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'h05, 8'h0C, 8'h80, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    plan[10] = frame_row(8'h00, 8'h00, CMD_STATUS, 8'h00, 8'h05, 8'h03, 8'h80, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    // Mode updates: top code, an out-of-range code that is kept out, zero.
    plan[11] = frame_row(8'h00, 8'h00, CMD_MODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    plan[12] = frame_row(8'h00, 8'h00, CMD_MODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    plan[13] = frame_row(8'h00, 8'h00, CMD_MODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    // Start mark bytes inside a frame are plain data.
    plan[14] = frame_row(START_MARK_RST, START_MARK_RST, START_MARK_RST, START_MARK_RST,
                         START_MARK_RST, START_MARK_RST, START_MARK_RST, START_MARK_RST,
                         8'h00, END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    // Frame to the pause address opens a send window.
    plan[15] = frame_row(8'h00, PAUSE_DEST_RST, CMD_STATUS, 8'h5A, 8'h11, 8'h0A, 8'h00,
                         8'h01, 8'h00, END_MARK_RST, 1'b1, 1'b0, NO_CHECK);
    // Valid mode frame from a foreign source is not tracked.
    plan[16] = frame_row(8'hFF, 8'h00, CMD_MODE, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00,
                         END_MARK_RST, 1'b1, 1'b0, NO_CHECK);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_NOISE) begin
        send_byte(plan[k].bytes[0]);
      end else begin
        use_typed    = plan[k].typed;
        typed_result = plan[k].want;
        send_frame(plan[k].bytes, plan[k].fix_sum);
        use_typed    = 1'b0;
      end
    end
    wait_idle();

    program_regs(START_MARK_RST, END_MARK_RST, PAUSE_DEST_RST, 8'h10, 8'h20);
    random_phase(1'b1);
    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    random_phase(1'b0);
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_phase(1'b1);
    repeat (2) begin
      program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      random_phase(1'b0);
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && frame_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
src/hbfs_pkg.sv
src/hbfs_in_if.sv
src/hbfs_out_if.sv
src/hbfs_collector.sv
src/hbfs_tracker.sv
src/hvac_bus_frame_status_decoder.sv
src/hbfs_checker.sv
tb/hvac_bus_frame_status_decoder_test.sv
